>>> hdl/nkps_pkg.sv
package nkps_pkg;

   // table and slot sizing
   localparam int TABLE_DEPTH = 256;
   localparam int MAX_SLOTS   = 16;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ENT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   // item field widths
   localparam int COORD_W       = 24;
   localparam int INDEX_FIELD_W = 8;
   localparam int SLOT_FIELD_W  = 4;
   localparam int PT_W          = 3 * COORD_W;
   localparam int DIFF_W        = COORD_W + 1;
   localparam int SQ_W          = 2 * COORD_W + 1;
   localparam int DIST_W        = SQ_W + 1;

   // configuration registers
   localparam int LAMP_W     = 9;
   localparam int ACT_W      = 5;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_LAMP_COUNT    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LIGHTS = 8'd1;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // cycles from the last table read until the ranked list is settled
   localparam int DRAIN_CYC = 4;
   localparam int DRAIN_W   = $clog2(DRAIN_CYC + 1);

   typedef struct packed {
      logic                      func;
      logic [INDEX_FIELD_W-1:0]  entry_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic                      night;
   } req_item_type;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0]   slot;
      logic                      visible;
      logic [INDEX_FIELD_W-1:0]  point_index;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      last;
   } rsp_item_type;

   // table read tag travelling alongside the read data
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] index;
   } issue_type;

   // scored candidate handed to the ranking list
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] index;
      logic [DIST_W-1:0] dist_sq;
   } cand_type;

endpackage

>>> hdl/nearest_k_point_select_unit.sv
// Load item: written into the point table at the accept edge, no result.
// Night query over E entries and W slots: the table scan and a drain of the distance
// pipe, then W results back to back; busy drops after the last.
// Day query: no table scan; W hidden results back to back.
// The scan reads one table entry per cycle from the single RAM port.
// Synchronous active-high reset clears control and configuration; table is not cleared.
module nearest_k_point_select_unit (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               start,
   output logic                               busy,
   input  nkps_pkg::req_item_type             req_item,
   // result channel
   output logic                               rsp_valid,
   output nkps_pkg::rsp_item_type             rsp_item,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nkps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nkps_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // sequencer state codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;

   // configuration
   logic [nkps_pkg::LAMP_W-1:0] lamp_count_ff, lamp_count_in;
   logic [nkps_pkg::ACT_W-1:0]  active_lights_ff, active_lights_in;

   // per-query context
   logic [nkps_pkg::ENT_W-1:0]          entries_ff, entries_in, entries_calc;
   logic [nkps_pkg::CNT_W-1:0]          want_ff, want_in, want_calc, act_lim;
   logic                                night_ff, night_in;
   logic signed [nkps_pkg::COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;

   // counters
   logic [nkps_pkg::ADDR_W-1:0]  scan_addr_ff, scan_addr_in;
   logic [nkps_pkg::DRAIN_W-1:0] drain_ff, drain_in;
   logic [nkps_pkg::SLOT_W-1:0]  k_ff, k_in;

   // emit stage, lines up with the registered RAM read
   logic                               e_valid_ff, e_valid_in;
   logic                               e_vis_ff, e_vis_in;
   logic                               e_last_ff, e_last_in;
   logic [nkps_pkg::SLOT_FIELD_W-1:0]  e_slot_ff, e_slot_in;
   logic [nkps_pkg::INDEX_FIELD_W-1:0] e_idx_ff, e_idx_in;

   logic accept, query_go, load_we, scan_last, emit_last;

   // table port
   logic                        ram_en;
   logic [nkps_pkg::ADDR_W-1:0] ram_addr;
   logic [nkps_pkg::PT_W-1:0]   ram_wdata, ram_rdata;

   nkps_pkg::issue_type issue;
   nkps_pkg::cand_type  cand;
   logic [nkps_pkg::MAX_SLOTS-1:0][nkps_pkg::ADDR_W-1:0] best_idx;
   logic [nkps_pkg::ADDR_W-1:0] emit_idx;

   // Hold busy through the emit stage so a new item never overlaps a result.
   assign busy      = (state_ff != ST_IDLE) || e_valid_ff;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Clamp the registers: entries to the table, slots to MAX_SLOTS and entries.
   always_comb begin
      if (32'(lamp_count_ff) > nkps_pkg::TABLE_DEPTH) begin
         entries_calc = nkps_pkg::ENT_W'(nkps_pkg::TABLE_DEPTH);
      end else begin
         entries_calc = nkps_pkg::ENT_W'(lamp_count_ff);
      end
      if (32'(active_lights_ff) > nkps_pkg::MAX_SLOTS) begin
         act_lim = nkps_pkg::CNT_W'(nkps_pkg::MAX_SLOTS);
      end else begin
         act_lim = nkps_pkg::CNT_W'(active_lights_ff);
      end
      if (32'(act_lim) > 32'(entries_calc)) begin
         want_calc = nkps_pkg::CNT_W'(entries_calc);
      end else begin
         want_calc = act_lim;
      end
   end

   // Drop loads beyond the table, and queries with no slot to fill.
   assign load_we  = accept && (req_item.func == nkps_pkg::FUNC_LOAD) &&
                     (32'(req_item.entry_index) < nkps_pkg::TABLE_DEPTH);
   assign query_go = accept && (req_item.func == nkps_pkg::FUNC_QUERY) &&
                     (want_calc != '0);

   assign scan_last = (nkps_pkg::ENT_W'(scan_addr_ff) + nkps_pkg::ENT_W'(1)) == entries_ff;
   assign emit_last = (nkps_pkg::CNT_W'(k_ff) + nkps_pkg::CNT_W'(1)) == want_ff;
   assign emit_idx  = best_idx[k_ff];

   // configuration writes; unknown indexes fall through
   always_comb begin
      lamp_count_in    = lamp_count_ff;
      active_lights_in = active_lights_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            nkps_pkg::CSR_LAMP_COUNT: begin
               lamp_count_in = csr_wdata[nkps_pkg::LAMP_W-1:0];
            end
            nkps_pkg::CSR_ACTIVE_LIGHTS: begin
               active_lights_in = csr_wdata[nkps_pkg::ACT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer: for a night query scan the table and let the distance pipe drain, then emit slots
   always_comb begin
      state_in     = state_ff;
      entries_in   = entries_ff;
      want_in      = want_ff;
      night_in     = night_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      scan_addr_in = scan_addr_ff;
      drain_in     = drain_ff;
      k_in         = k_ff;
      e_valid_in   = 1'b0;
      e_vis_in     = e_vis_ff;
      e_last_in    = e_last_ff;
      e_slot_in    = e_slot_ff;
      e_idx_in     = e_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               entries_in   = entries_calc;
               want_in      = want_calc;
               night_in     = req_item.night;
               qx_in        = req_item.coord_x;
               qy_in        = req_item.coord_y;
               scan_addr_in = '0;
               k_in         = '0;
               state_in     = req_item.night ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + nkps_pkg::ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + nkps_pkg::DRAIN_W'(1);
            if (drain_ff == nkps_pkg::DRAIN_W'(nkps_pkg::DRAIN_CYC - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            e_valid_in = 1'b1;
            e_vis_in   = night_ff;
            e_last_in  = emit_last;
            e_slot_in  = nkps_pkg::SLOT_FIELD_W'(k_ff);
            e_idx_in   = night_ff ? nkps_pkg::INDEX_FIELD_W'(emit_idx) : '0;
            if (emit_last) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + nkps_pkg::SLOT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // table port: loads write, the scan and visible slots read
   always_comb begin
      ram_wdata = {req_item.coord_z, req_item.coord_y, req_item.coord_x};
      case (state_ff)
         ST_SCAN: ram_addr = scan_addr_ff;
         ST_EMIT: ram_addr = emit_idx;
         default: ram_addr = nkps_pkg::ADDR_W'(req_item.entry_index);
      endcase
      ram_en = load_we || (state_ff == ST_SCAN) || ((state_ff == ST_EMIT) && night_ff);
   end

   assign issue.valid = (state_ff == ST_SCAN);
   assign issue.index = scan_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         lamp_count_ff    <= '0;
         active_lights_ff <= '0;
         e_valid_ff       <= 1'b0;
      end else begin
         state_ff         <= state_in;
         lamp_count_ff    <= lamp_count_in;
         active_lights_ff <= active_lights_in;
         e_valid_ff       <= e_valid_in;
      end
      entries_ff   <= entries_in;
      want_ff      <= want_in;
      night_ff     <= night_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      scan_addr_ff <= scan_addr_in;
      drain_ff     <= drain_in;
      k_ff         <= k_in;
      e_vis_ff     <= e_vis_in;
      e_last_ff    <= e_last_in;
      e_slot_ff    <= e_slot_in;
      e_idx_ff     <= e_idx_in;
   end

   nkps_ram #(
      .WIDTH (nkps_pkg::PT_W),
      .DEPTH (nkps_pkg::TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .en    (ram_en),
      .we    (load_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   nkps_dist u_dist (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .rdata (ram_rdata),
      .qx    (qx_ff),
      .qy    (qy_ff),
      .cand  (cand)
   );

   nkps_rank u_rank (
      .clock    (clock),
      .reset    (reset),
      .clear    (query_go),
      .cand     (cand),
      .best_idx (best_idx)
   );

   // result: emit stage plus the registered point read of the same slot; zero when hidden
   always_comb begin
      rsp_valid            = e_valid_ff;
      rsp_item.slot        = e_slot_ff;
      rsp_item.visible     = e_vis_ff;
      rsp_item.point_index = e_idx_ff;
      rsp_item.last        = e_last_ff;
      if (e_vis_ff) begin
         rsp_item.point_x = ram_rdata[nkps_pkg::COORD_W-1:0];
         rsp_item.point_y = ram_rdata[2*nkps_pkg::COORD_W-1:nkps_pkg::COORD_W];
         rsp_item.point_z = ram_rdata[3*nkps_pkg::COORD_W-1:2*nkps_pkg::COORD_W];
      end else begin
         rsp_item.point_x = '0;
         rsp_item.point_y = '0;
         rsp_item.point_z = '0;
      end
   end

`ifndef SYNTH
   // results only come while the unit reports busy
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside a busy window");

   // slots of one query arrive back to back
   a_rsp_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.last) |=> rsp_valid)
      else $error("gap inside a result burst");

   // nothing follows the final slot directly
   a_rsp_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last) |=> !rsp_valid)
      else $error("result after final slot");

   // scanning never overlaps result delivery
   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> !rsp_valid)
      else $error("result during table scan");
`endif

endmodule

>>> hdl/nkps_ram.sv
module nkps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          en,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                              wdata,
   output logic [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/nkps_dist.sv
module nkps_dist (
   input  logic                              clock,
   input  logic                              reset,
   input  nkps_pkg::issue_type               issue,
   input  logic [nkps_pkg::PT_W-1:0]         rdata,
   input  logic signed [nkps_pkg::COORD_W-1:0] qx,
   input  logic signed [nkps_pkg::COORD_W-1:0] qy,
   output nkps_pkg::cand_type                cand
);

   nkps_pkg::issue_type tag1_ff, tag2_ff, tag3_ff;
   nkps_pkg::issue_type tag2_in, tag3_in;
   nkps_pkg::cand_type  cand_ff, cand_in;

   logic signed [nkps_pkg::COORD_W-1:0]  px, py;
   logic signed [nkps_pkg::DIFF_W-1:0]   dx_ff, dy_ff, dx_in, dy_in;
   logic signed [2*nkps_pkg::DIFF_W-1:0] prod_x, prod_y;
   logic [nkps_pkg::SQ_W-1:0]            sqx_ff, sqy_ff, sqx_in, sqy_in;

   // stage 1: difference against the query location
   always_comb begin
      px      = rdata[nkps_pkg::COORD_W-1:0];
      py      = rdata[2*nkps_pkg::COORD_W-1:nkps_pkg::COORD_W];
      dx_in   = {px[nkps_pkg::COORD_W-1], px} - {qx[nkps_pkg::COORD_W-1], qx};
      dy_in   = {py[nkps_pkg::COORD_W-1], py} - {qy[nkps_pkg::COORD_W-1], qy};
      tag2_in = tag1_ff;
   end

   // stage 2: square each axis
   always_comb begin
      prod_x  = dx_ff * dx_ff;
      prod_y  = dy_ff * dy_ff;
      sqx_in  = prod_x[nkps_pkg::SQ_W-1:0];
      sqy_in  = prod_y[nkps_pkg::SQ_W-1:0];
      tag3_in = tag2_ff;
   end

   // stage 3: sum of squares
   always_comb begin
      cand_in.valid   = tag3_ff.valid;
      cand_in.index   = tag3_ff.index;
      cand_in.dist_sq = nkps_pkg::DIST_W'(sqx_ff) + nkps_pkg::DIST_W'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         cand_ff.valid <= 1'b0;
      end else begin
         tag1_ff.valid <= issue.valid;
         tag2_ff.valid <= tag2_in.valid;
         tag3_ff.valid <= tag3_in.valid;
         cand_ff.valid <= cand_in.valid;
      end
      tag1_ff.index   <= issue.index;
      tag2_ff.index   <= tag2_in.index;
      tag3_ff.index   <= tag3_in.index;
      cand_ff.index   <= cand_in.index;
      cand_ff.dist_sq <= cand_in.dist_sq;
      dx_ff           <= dx_in;
      dy_ff           <= dy_in;
      sqx_ff          <= sqx_in;
      sqy_ff          <= sqy_in;
   end

   assign cand = cand_ff;

endmodule

>>> hdl/nkps_rank.sv
module nkps_rank (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  clear,
   input  nkps_pkg::cand_type                                    cand,
   output logic [nkps_pkg::MAX_SLOTS-1:0][nkps_pkg::ADDR_W-1:0] best_idx
);

   logic [nkps_pkg::MAX_SLOTS-1:0]                       valid_ff, valid_in;
   logic [nkps_pkg::MAX_SLOTS-1:0]                       lt;
   logic [nkps_pkg::MAX_SLOTS-1:0][nkps_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic [nkps_pkg::MAX_SLOTS-1:0][nkps_pkg::ADDR_W-1:0] idx_ff, idx_in;

   // Sorted list, nearest first. A strict compare keeps ties behind the
   // earlier (lower) index. lt is a thermometer: every slot at or after the
   // insert point sees it set.
   for (genvar j = 0; j < nkps_pkg::MAX_SLOTS; j++) begin : g_slot
      assign lt[j] = !valid_ff[j] || (cand.dist_sq < dist_ff[j]);
      if (j == 0) begin : g_head
         always_comb begin
            dist_in[j]  = dist_ff[j];
            idx_in[j]   = idx_ff[j];
            valid_in[j] = valid_ff[j];
            if (clear) begin
               valid_in[j] = 1'b0;
            end else if (cand.valid && lt[j]) begin
               dist_in[j]  = cand.dist_sq;
               idx_in[j]   = cand.index;
               valid_in[j] = 1'b1;
            end
         end
      end else begin : g_tail
         always_comb begin
            dist_in[j]  = dist_ff[j];
            idx_in[j]   = idx_ff[j];
            valid_in[j] = valid_ff[j];
            if (clear) begin
               valid_in[j] = 1'b0;
            end else if (cand.valid && lt[j]) begin
               // shift down from the neighbor, or take the new entry here
               if (lt[j-1]) begin
                  dist_in[j] = dist_ff[j-1];
                  idx_in[j]  = idx_ff[j-1];
               end else begin
                  dist_in[j] = cand.dist_sq;
                  idx_in[j]  = cand.index;
               end
               valid_in[j] = valid_ff[j] | valid_ff[j-1] | !lt[j-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      dist_ff <= dist_in;
      idx_ff  <= idx_in;
   end

   assign best_idx = idx_ff;

endmodule
